// ----- design/pmmkm_pkg.sv -----
// Shared types and constants of the periodic mesh material key map.
package pmmkm_pkg;

    localparam int MAX_UNIQUE_NODES_DEF = 65536;
    localparam int SLOT_BITS_DEF        = 8;

    localparam int NY_W    = 13;  // nodes per column
    localparam int UNQ_W   = 17;  // unique node count
    localparam int DOF_W   = 2;
    localparam int IDX_W   = 18;
    localparam int MAT_W   = 8;
    localparam int OFS_W   = 18;
    localparam int KEY_W   = 32;
    localparam int KIND_W  = 2;
    localparam int NODE_W  = 20;  // widest raw corner node
    localparam int DVS_W   = 17;  // divisor width of the shared divider
    localparam int QDEPTH  = 4;   // op queue between front and back

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_MAP   = 2'd3;

    localparam logic [1:0] REG_NY   = 2'd0;
    localparam logic [1:0] REG_UNQ  = 2'd1;
    localparam logic [1:0] REG_DOFS = 2'd2;

    typedef struct packed {
        logic              start;
        logic [NODE_W-1:0] dividend;
        logic [DVS_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [NODE_W-1:0] quo;
        logic [DVS_W-1:0]  rem;
    } t_div_rsp;

endpackage

// ----- design/periodic_mesh_material_key_map_core.sv -----
// Top level of the periodic mesh material key map.
//
// Maps nodes of a column-major periodic 2D quad mesh to unique nodes and keeps
// a packed four-slot material key per unique node. Requests come in through a
// queue-style push/full port: clear entry, add element material, read entry,
// map node. Every request gives exactly one result on the pop/empty side, in
// order; only reads carry a key and only node maps carry a dof offset. The
// front end takes one request at a time and resolves nodes with one shared
// restoring divider; the back end does table read-modify-writes from a 4-deep
// op queue. An element add takes one divide for the element base, then two
// divides per corner. The table is not cleared by reset: clear every entry
// before accumulating into it. Configuration goes through the APB port at byte
// addresses 0, 4 and 8; the user must write it only while no request is in
// flight, and the block itself does not enforce it.
module periodic_mesh_material_key_map_core #(
    parameter int MAX_UNIQUE_NODES = pmmkm_pkg::MAX_UNIQUE_NODES_DEF,
    parameter int SLOT_BITS        = pmmkm_pkg::SLOT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [pmmkm_pkg::KIND_W-1:0]        i_kind,
    input  logic [pmmkm_pkg::IDX_W-1:0]         i_index,
    input  logic [pmmkm_pkg::MAT_W-1:0]         i_material,
    output logic                                empty,
    input  logic                                pop,
    output logic [pmmkm_pkg::OFS_W-1:0]         o_dof_offset,
    output logic [pmmkm_pkg::KEY_W-1:0]         o_material_key,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    localparam int AW  = $clog2(MAX_UNIQUE_NODES);
    localparam int OPW = pmmkm_pkg::KIND_W + AW + 1 + 2 + SLOT_BITS
                       + pmmkm_pkg::OFS_W + 1;

    // config registers
    logic [pmmkm_pkg::NY_W-1:0]  r_ny;
    logic [pmmkm_pkg::UNQ_W-1:0] r_unq;
    logic [pmmkm_pkg::DOF_W-1:0] r_dofs;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ny   <= pmmkm_pkg::NY_W'(2);
            r_unq  <= pmmkm_pkg::UNQ_W'(1);
            r_dofs <= pmmkm_pkg::DOF_W'(1);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                pmmkm_pkg::REG_NY:   r_ny   <= pwdata[pmmkm_pkg::NY_W-1:0];
                pmmkm_pkg::REG_UNQ:  r_unq  <= pwdata[pmmkm_pkg::UNQ_W-1:0];
                pmmkm_pkg::REG_DOFS: r_dofs <= pwdata[pmmkm_pkg::DOF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            pmmkm_pkg::REG_NY:   prdata = 32'(r_ny);
            pmmkm_pkg::REG_UNQ:  prdata = 32'(r_unq);
            pmmkm_pkg::REG_DOFS: prdata = 32'(r_dofs);
            default:             prdata = '0;
        endcase
    end

    pmmkm_pkg::t_div_req div_req;
    pmmkm_pkg::t_div_rsp div_rsp;
    logic                q_push, q_full, q_empty, q_pop;
    logic [OPW-1:0]      q_wdata, q_rdata;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [31:0]         ram_wdata, ram_rdata;

    pmmkm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    pmmkm_front #(
        .MAX_UNIQUE_NODES (MAX_UNIQUE_NODES),
        .SLOT_BITS        (SLOT_BITS),
        .AW               (AW),
        .OPW              (OPW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_kind     (i_kind),
        .i_index    (i_index),
        .i_material (i_material),
        .o_full     (full),
        .i_ny       (r_ny),
        .i_unq      (r_unq),
        .i_dofs     (r_dofs),
        .o_div      (div_req),
        .i_div      (div_rsp),
        .o_qpush    (q_push),
        .o_qdata    (q_wdata),
        .i_qfull    (q_full)
    );

    pmmkm_queue #(.WIDTH(OPW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    pmmkm_ram #(.WIDTH(pmmkm_pkg::KEY_W), .DEPTH(MAX_UNIQUE_NODES)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pmmkm_back #(
        .MAX_UNIQUE_NODES (MAX_UNIQUE_NODES),
        .SLOT_BITS        (SLOT_BITS),
        .AW               (AW),
        .OPW              (OPW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_qempty       (q_empty),
        .i_qdata        (q_rdata),
        .o_qpop         (q_pop),
        .o_we           (ram_we),
        .o_waddr        (ram_waddr),
        .o_wdata        (ram_wdata),
        .o_raddr        (ram_raddr),
        .i_rdata        (ram_rdata),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_dof_offset   (o_dof_offset),
        .o_material_key (o_material_key)
    );

    // result register starts empty
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result visible after reset");

    // an accepted request keeps the front busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> full)
        else $error("front free right after accepting a request");

    // front never pushes into a full op queue
    a_queue_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("op queue overflow");
endmodule

// ----- design/pmmkm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pmmkm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/pmmkm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module pmmkm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pmmkm_pkg::t_div_req i_req,
    output pmmkm_pkg::t_div_rsp o_rsp
);
    localparam int NW = pmmkm_pkg::NODE_W;
    localparam int DW = pmmkm_pkg::DVS_W;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW:0]   sh;
    logic [DW:0]   trial;

    assign sh    = {r_rem, r_quo[NW-1]};
    assign trial = sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quo <= i_req.dividend;
                r_rem <= '0;
                r_dvs <= i_req.divisor;
                r_cnt <= CW'(NW);
            end else if (r_cnt != '0) begin
                if (!trial[DW]) begin
                    r_rem <= trial[DW-1:0];
                    r_quo <= {r_quo[NW-2:0], 1'b1};
                end else begin
                    r_rem <= sh[DW-1:0];
                    r_quo <= {r_quo[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;
endmodule

// ----- design/pmmkm_queue.sv -----
// Small register queue carrying table ops from front to back.
module pmmkm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int D  = pmmkm_pkg::QDEPTH;
    localparam int PW = $clog2(D);

    logic [WIDTH-1:0] r_buf [D];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [PW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (PW+1)'(D));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_buf[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

// ----- design/pmmkm_front.sv -----
// Front end: accepts requests, finds corner and unique nodes, queues table ops.
module pmmkm_front #(
    parameter int MAX_UNIQUE_NODES = pmmkm_pkg::MAX_UNIQUE_NODES_DEF,
    parameter int SLOT_BITS        = pmmkm_pkg::SLOT_BITS_DEF,
    parameter int AW               = $clog2(MAX_UNIQUE_NODES),
    parameter int OPW              = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic [pmmkm_pkg::KIND_W-1:0]      i_kind,
    input  logic [pmmkm_pkg::IDX_W-1:0]       i_index,
    input  logic [pmmkm_pkg::MAT_W-1:0]       i_material,
    output logic                              o_full,
    input  logic [pmmkm_pkg::NY_W-1:0]        i_ny,
    input  logic [pmmkm_pkg::UNQ_W-1:0]       i_unq,
    input  logic [pmmkm_pkg::DOF_W-1:0]       i_dofs,
    output pmmkm_pkg::t_div_req               o_div,
    input  pmmkm_pkg::t_div_rsp               i_div,
    output logic                              o_qpush,
    output logic [OPW-1:0]                    o_qdata,
    input  logic                              i_qfull
);
    localparam int NW = pmmkm_pkg::NODE_W;
    localparam int DW = pmmkm_pkg::DVS_W;
    localparam logic [31:0] MAT_MASK = 32'((64'(1) << SLOT_BITS) - 64'(1));
    localparam logic [31:0] MAX32    = 32'(MAX_UNIQUE_NODES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EDIV   = 3'd1;
    localparam logic [2:0] S_CSTART = 3'd2;
    localparam logic [2:0] S_NDIV   = 3'd3;
    localparam logic [2:0] S_UDIV   = 3'd4;
    localparam logic [2:0] S_PUSH   = 3'd5;

    logic [2:0]                    r_state, n_state;
    logic [pmmkm_pkg::KIND_W-1:0]  r_kind;
    logic [pmmkm_pkg::IDX_W-1:0]   r_idx;
    logic [SLOT_BITS-1:0]          r_mat;
    logic [NW-1:0]                 r_base;
    logic [1:0]                    r_corner;
    logic [DW-1:0]                 r_uniq;
    logic                          r_inr;

    logic [pmmkm_pkg::NY_W-1:0]    ny_eff;
    logic [pmmkm_pkg::NY_W-1:0]    d;
    logic [pmmkm_pkg::UNQ_W-1:0]   u_tmp;
    logic [DW-1:0]                 u_eff;
    logic [NW-1:0]                 node;
    logic [NW-1:0]                 v;
    logic [31:0]                   m32;
    logic [18:0]                   prod;
    logic [31:0]                   addr32;
    logic                          last;
    logic                          accept;

    assign ny_eff = (i_ny < pmmkm_pkg::NY_W'(2)) ? pmmkm_pkg::NY_W'(2) : i_ny;
    assign d      = ny_eff - 1'b1;
    assign u_tmp  = (i_unq == '0) ? pmmkm_pkg::UNQ_W'(1) : i_unq;
    assign u_eff  = (32'(u_tmp) > MAX32) ? MAX32[DW-1:0] : u_tmp;
    assign accept = i_push && (r_state == S_IDLE);
    assign o_full = (r_state != S_IDLE);
    assign m32    = 32'(i_material) & MAT_MASK;

    always_comb begin
        case (r_corner)
            2'd0:    node = r_base + NW'(1);
            2'd1:    node = r_base + NW'(1) + NW'(ny_eff);
            2'd2:    node = r_base + NW'(ny_eff);
            default: node = r_base;
        endcase
    end

    // periodic fold: drop top row, subtract column count
    assign v = node - i_div.quo
             - ((i_div.rem[pmmkm_pkg::NY_W-1:0] == d) ? NW'(d) : NW'(0));

    always_comb begin
        n_state        = r_state;
        o_div.start    = 1'b0;
        o_div.dividend = '0;
        o_div.divisor  = '0;
        o_qpush        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == pmmkm_pkg::KIND_ADD) begin
                        o_div.start    = 1'b1;
                        o_div.dividend = NW'(i_index);
                        o_div.divisor  = DW'(d);
                        n_state        = S_EDIV;
                    end else if (i_kind == pmmkm_pkg::KIND_MAP) begin
                        n_state = S_CSTART;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_EDIV: begin
                if (i_div.done) n_state = S_CSTART;
            end
            S_CSTART: begin
                o_div.start    = 1'b1;
                o_div.dividend = node;
                o_div.divisor  = DW'(ny_eff);
                n_state        = S_NDIV;
            end
            S_NDIV: begin
                if (i_div.done) begin
                    o_div.start    = 1'b1;
                    o_div.dividend = v;
                    o_div.divisor  = u_eff;
                    n_state        = S_UDIV;
                end
            end
            S_UDIV: begin
                if (i_div.done) n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!i_qfull) begin
                    o_qpush = 1'b1;
                    n_state = last ? S_IDLE : S_CSTART;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign last   = (r_kind != pmmkm_pkg::KIND_ADD) || (r_corner == 2'd3);
    assign prod   = 19'(r_uniq) * 19'(i_dofs);
    assign addr32 = ((r_kind == pmmkm_pkg::KIND_CLEAR) || (r_kind == pmmkm_pkg::KIND_READ))
                  ? 32'(r_idx) : 32'(r_uniq);
    assign o_qdata = {r_kind, addr32[AW-1:0], r_inr, r_corner, r_mat,
                      prod[pmmkm_pkg::OFS_W-1:0], last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_idx  <= i_index;
            r_mat  <= m32[SLOT_BITS-1:0];
            r_inr  <= (i_kind == pmmkm_pkg::KIND_ADD) || (i_kind == pmmkm_pkg::KIND_MAP)
                   || (32'(i_index) < MAX32);
            r_base <= NW'(i_index);
            r_corner <= (i_kind == pmmkm_pkg::KIND_MAP) ? 2'd3 : 2'd0;
        end
        if (r_state == S_EDIV && i_div.done) begin
            r_base   <= NW'(r_idx) + i_div.quo;
            r_corner <= 2'd0;
        end
        if (r_state == S_UDIV && i_div.done) begin
            r_uniq <= i_div.rem;
        end
        if (r_state == S_PUSH && !i_qfull && !last) begin
            r_corner <= r_corner + 1'b1;
        end
    end
endmodule

// ----- design/pmmkm_back.sv -----
// Back end: runs queued ops on the key table and holds the result register.
module pmmkm_back #(
    parameter int MAX_UNIQUE_NODES = pmmkm_pkg::MAX_UNIQUE_NODES_DEF,
    parameter int SLOT_BITS        = pmmkm_pkg::SLOT_BITS_DEF,
    parameter int AW               = $clog2(MAX_UNIQUE_NODES),
    parameter int OPW              = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_qempty,
    input  logic [OPW-1:0]                i_qdata,
    output logic                          o_qpop,
    output logic                          o_we,
    output logic [AW-1:0]                 o_waddr,
    output logic [pmmkm_pkg::KEY_W-1:0]   o_wdata,
    output logic [AW-1:0]                 o_raddr,
    input  logic [pmmkm_pkg::KEY_W-1:0]   i_rdata,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [pmmkm_pkg::OFS_W-1:0]   o_dof_offset,
    output logic [pmmkm_pkg::KEY_W-1:0]   o_material_key
);
    localparam logic B_IDLE = 1'b0;
    localparam logic B_RD   = 1'b1;

    logic [pmmkm_pkg::KIND_W-1:0] q_kind, r_kind;
    logic [AW-1:0]                q_addr, r_addr;
    logic                         q_inr;
    logic [1:0]                   q_slot, r_slot;
    logic [SLOT_BITS-1:0]         q_mat, r_mat;
    logic [pmmkm_pkg::OFS_W-1:0]  q_ofs;
    logic                         q_last, r_last;

    logic                         r_state, n_state;
    logic                         r_ovalid;
    logic [pmmkm_pkg::OFS_W-1:0]  r_ofs, n_ofs;
    logic [pmmkm_pkg::KEY_W-1:0]  r_key, n_key;
    logic                         emit;
    logic                         take;
    logic [31:0]                  addend;

    assign {q_kind, q_addr, q_inr, q_slot, q_mat, q_ofs, q_last} = i_qdata;
    assign take   = (r_state == B_IDLE) && !i_qempty && !r_ovalid;
    assign o_qpop = take;
    assign addend = 32'(r_mat) << (r_slot * SLOT_BITS);
    assign o_raddr = q_addr;
    assign o_waddr = take ? q_addr : r_addr;

    always_comb begin
        n_state = r_state;
        emit    = 1'b0;
        n_ofs   = '0;
        n_key   = '0;
        o_we    = 1'b0;
        o_wdata = '0;
        unique case (r_state)
            B_IDLE: begin
                if (take) begin
                    unique case (q_kind)
                        pmmkm_pkg::KIND_CLEAR: begin
                            o_we = q_inr;
                            emit = 1'b1;
                        end
                        pmmkm_pkg::KIND_ADD: n_state = B_RD;
                        pmmkm_pkg::KIND_READ: begin
                            if (q_inr) n_state = B_RD;
                            else       emit    = 1'b1;
                        end
                        default: begin
                            emit  = 1'b1;
                            n_ofs = q_ofs;
                        end
                    endcase
                end
            end
            default: begin
                n_state = B_IDLE;
                if (r_kind == pmmkm_pkg::KIND_ADD) begin
                    o_we    = 1'b1;
                    o_wdata = i_rdata + addend;
                    emit    = r_last;
                end else begin
                    emit  = 1'b1;
                    n_key = i_rdata;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit)       r_ovalid <= 1'b1;
            else if (i_pop) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind <= q_kind;
            r_addr <= q_addr;
            r_slot <= q_slot;
            r_mat  <= q_mat;
            r_last <= q_last;
        end
        if (emit) begin
            r_ofs <= n_ofs;
            r_key <= n_key;
        end
    end

    assign o_empty        = !r_ovalid;
    assign o_dof_offset   = r_ofs;
    assign o_material_key = r_key;
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the periodic mesh material key map core.
`timescale 1ns / 1ps
module tb_top;

    localparam int NENT      = pmmkm_pkg::MAX_UNIQUE_NODES_DEF;
    localparam int WDOG_MAX  = 20000;  // cycles with no handshake at all
    localparam int DRAIN_CYC = 400;    // element add latency plus margin

    typedef struct packed {
        logic [pmmkm_pkg::KIND_W-1:0] kind;
        logic [pmmkm_pkg::IDX_W-1:0]  index;
        logic [pmmkm_pkg::MAT_W-1:0]  material;
    } t_req;

    typedef struct packed {
        logic [pmmkm_pkg::OFS_W-1:0] dof_offset;
        logic [pmmkm_pkg::KEY_W-1:0] material_key;
    } t_rsp;

    logic                         clk;
    logic                         rst_n;
    logic                         push;
    logic                         full;
    logic [pmmkm_pkg::KIND_W-1:0] kind_d;
    logic [pmmkm_pkg::IDX_W-1:0]  index_d;
    logic [pmmkm_pkg::MAT_W-1:0]  material_d;
    logic                         empty;
    logic                         pop;
    logic [pmmkm_pkg::OFS_W-1:0]  dof_offset;
    logic [pmmkm_pkg::KEY_W-1:0]  material_key;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [3:0]                   paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    periodic_mesh_material_key_map_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (kind_d),
        .i_index        (index_d),
        .i_material     (material_d),
        .empty          (empty),
        .pop            (pop),
        .o_dof_offset   (dof_offset),
        .o_material_key (material_key),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Predictor state: shadow registers and key table.
    logic [31:0]                  key_shadow [NENT];
    bit                           key_written [NENT];  // entry cleared since reset
    logic [pmmkm_pkg::NY_W-1:0]   ny_reg;
    logic [pmmkm_pkg::UNQ_W-1:0]  unq_reg;
    logic [pmmkm_pkg::DOF_W-1:0]  dofs_reg;

    t_req pending_reqs[$];   // fed to the driver
    t_rsp expected_rsps[$];  // filled at acceptance

    int  err_count;
    int  wdog;
    int  send_gap;
    int  pop_gap;
    bit  timed_out;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("tb_top: mismatch %s got %0h want %0h", what, got, want);
        err_count++;
    endtask

    // Effective column height and node count after clamping.
    function automatic longint unsigned col_height();
        return (ny_reg < 2) ? 2 : ny_reg;
    endfunction

    function automatic longint unsigned node_count();
        longint unsigned u;
        u = unq_reg;
        if (u == 0) u = 1;
        if (u > NENT) u = NENT;
        return u;
    endfunction

    // Raw node to unique periodic node: drop the top row, wrap the count.
    function automatic longint unsigned periodic_node(input longint unsigned n);
        longint unsigned ny, d, col, row, v;
        ny  = col_height();
        d   = ny - 1;
        col = n / ny;
        row = n % ny;
        v   = n - col - ((row == d) ? d : 0);
        return v % node_count();
    endfunction

    function automatic void add_to_corner(input longint unsigned node,
                                          input logic [31:0] mat, input int slot);
        longint unsigned u;
        u = periodic_node(node);
        key_shadow[u] = key_shadow[u] + (mat << (slot * pmmkm_pkg::SLOT_BITS_DEF));
    endfunction

    // Apply one accepted request, return its expected result.
    function automatic t_rsp predict_request(input t_req r);
        t_rsp o;
        longint unsigned ny, base, ofs;
        logic [31:0] m;
        o = '0;
        case (r.kind)
            pmmkm_pkg::KIND_CLEAR: begin
                if (r.index < NENT) begin
                    key_shadow[r.index]  = '0;
                    key_written[r.index] = 1'b1;
                end
            end
            pmmkm_pkg::KIND_ADD: begin
                ny   = col_height();
                base = r.index + r.index / (ny - 1);
                m    = r.material & ((1 << pmmkm_pkg::SLOT_BITS_DEF) - 1);
                add_to_corner(base + 1, m, 0);       // left-bottom
                add_to_corner(base + 1 + ny, m, 1);  // right-bottom
                add_to_corner(base + ny, m, 2);      // right-top
                add_to_corner(base, m, 3);           // left-top
            end
            pmmkm_pkg::KIND_READ: begin
                if (r.index < NENT) o.material_key = key_shadow[r.index];
            end
            default: begin
                ofs = periodic_node(r.index) * dofs_reg;
                o.dof_offset = ofs[pmmkm_pkg::OFS_W-1:0];
            end
        endcase
        return o;
    endfunction

    // Driver: one request at a time from pending_reqs, random gap before each.
    always @(posedge clk) begin
        if (!rst_n) begin
            push     <= 1'b0;
            send_gap <= 0;
        end else if (push && !full) begin
            expected_rsps.push_back(predict_request('{kind_d, index_d, material_d}));
            void'(pending_reqs.pop_front());
            push     <= 1'b0;
            send_gap <= $urandom_range(0, 5);
        end else if (!push) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                push       <= 1'b1;
                kind_d     <= pending_reqs[0].kind;
                index_d    <= pending_reqs[0].index;
                material_d <= pending_reqs[0].material;
            end
        end
    end

    // Monitor: pops with random stalls and checks each result in order.
    always @(posedge clk) begin
        t_rsp want;
        if (!rst_n) begin
            pop     <= 1'b0;
            pop_gap <= 0;
        end else begin
            if (pop && !empty) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected result", 64'(material_key), 64'(0));
                end else begin
                    want = expected_rsps.pop_front();
                    if (dof_offset !== want.dof_offset)
                        report_mismatch("dof_offset", 64'(dof_offset),
                                        64'(want.dof_offset));
                    if (material_key !== want.material_key)
                        report_mismatch("material_key", 64'(material_key),
                                        64'(want.material_key));
                end
                pop     <= 1'b0;
                pop_gap <= $urandom_range(0, 5);
            end else if (!pop) begin
                if (pop_gap > 0) pop_gap <= pop_gap - 1;
                else pop <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no request or result handshake.
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_MAX && !timed_out) begin
            timed_out = 1'b1;
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic queue_req(input logic [pmmkm_pkg::KIND_W-1:0] k, input int idx,
                             input int mat);
        t_req r;
        r.kind     = k;
        r.index    = idx[pmmkm_pkg::IDX_W-1:0];
        r.material = mat[pmmkm_pkg::MAT_W-1:0];
        pending_reqs.push_back(r);
    endtask

    // Wait until every request is in and answered, then let the back end settle.
    task automatic wait_idle();
        while (pending_reqs.size() > 0 || push || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_id, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_id)
            pmmkm_pkg::REG_NY:  ny_reg   = val[pmmkm_pkg::NY_W-1:0];
            pmmkm_pkg::REG_UNQ: unq_reg  = val[pmmkm_pkg::UNQ_W-1:0];
            default:            dofs_reg = val[pmmkm_pkg::DOF_W-1:0];
        endcase
    endtask

    task automatic set_mesh(input int ny, input int unq, input int dofs);
        apb_write(pmmkm_pkg::REG_NY, ny);
        apb_write(pmmkm_pkg::REG_UNQ, unq);
        apb_write(pmmkm_pkg::REG_DOFS, dofs);
    endtask

    // Clear the entries a mesh can touch so later reads are well defined.
    task automatic clear_entries(input int count);
        for (int i = 0; i < count; i++) queue_req(pmmkm_pkg::KIND_CLEAR, i, $urandom);
    endtask

    // A written entry index, or an out-of-range one now and then.
    function automatic int pick_entry(input int count);
        int e;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(NENT, (1 << pmmkm_pkg::IDX_W) - 1);
        e = $urandom_range(0, count - 1);
        return key_written[e] ? e : 0;
    endfunction

    task automatic random_phase(input int nitems, input int count);
        int p;
        for (int i = 0; i < nitems; i++) begin
            p = $urandom_range(0, 99);
            if (p < 45)
                queue_req(pmmkm_pkg::KIND_ADD, ($urandom_range(0, 7) == 0) ? $urandom :
                          $urandom_range(0, 2 * count), $urandom);
            else if (p < 70)
                queue_req(pmmkm_pkg::KIND_READ, pick_entry(count), $urandom);
            else if (p < 90)
                queue_req(pmmkm_pkg::KIND_MAP, ($urandom_range(0, 3) == 0) ? $urandom :
                          $urandom_range(0, 4 * count), $urandom);
            else
                queue_req(pmmkm_pkg::KIND_CLEAR, ($urandom_range(0, 7) == 0) ?
                          $urandom_range(NENT, (1 << pmmkm_pkg::IDX_W) - 1) :
                          $urandom_range(0, count - 1), $urandom);
        end
    endtask

    initial begin
        int ny, unq;
        err_count = 0;
        timed_out = 1'b0;
        rst_n     = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        kind_d    = pmmkm_pkg::KIND_CLEAR;
        index_d   = '0;
        material_d = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        ny_reg    = 2;
        unq_reg   = 1;
        dofs_reg  = 1;
        for (int i = 0; i < NENT; i++) begin
            key_shadow[i]  = '0;
            key_written[i] = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, then small mesh with all kinds and edges.
        clear_entries(1);
        queue_req(pmmkm_pkg::KIND_ADD, 0, 8'hff);
        queue_req(pmmkm_pkg::KIND_READ, 0, 0);
        queue_req(pmmkm_pkg::KIND_MAP, 3, 0);
        wait_idle();

        set_mesh(4, 9, 2);
        clear_entries(9);
        queue_req(pmmkm_pkg::KIND_ADD, 0, 8'hff);
        queue_req(pmmkm_pkg::KIND_ADD, 8, 8'h01);
        queue_req(pmmkm_pkg::KIND_ADD, (1 << pmmkm_pkg::IDX_W) - 1, 8'haa);
        queue_req(pmmkm_pkg::KIND_READ, 0, 0);
        queue_req(pmmkm_pkg::KIND_READ, 8, 0);
        queue_req(pmmkm_pkg::KIND_READ, NENT, 0);
        queue_req(pmmkm_pkg::KIND_READ, (1 << pmmkm_pkg::IDX_W) - 1, 0);
        queue_req(pmmkm_pkg::KIND_CLEAR, (1 << pmmkm_pkg::IDX_W) - 1, 8'hff);
        queue_req(pmmkm_pkg::KIND_MAP, 3, 0);
        queue_req(pmmkm_pkg::KIND_MAP, 15, 0);
        queue_req(pmmkm_pkg::KIND_MAP, (1 << pmmkm_pkg::IDX_W) - 1, 0);
        wait_idle();

        // Clamped registers: column below 2, zero nodes, zero dofs.
        set_mesh(0, 0, 0);
        queue_req(pmmkm_pkg::KIND_MAP, 12345, 0);
        queue_req(pmmkm_pkg::KIND_ADD, 77, 8'h55);
        queue_req(pmmkm_pkg::KIND_READ, 0, 0);
        wait_idle();

        // Saturated node count, tallest column, most dofs.
        set_mesh(8191, 131071, 3);
        queue_req(pmmkm_pkg::KIND_MAP, (1 << pmmkm_pkg::IDX_W) - 1, 0);
        queue_req(pmmkm_pkg::KIND_MAP, 8190, 0);
        queue_req(pmmkm_pkg::KIND_MAP, 196607, 0);
        wait_idle();
        set_mesh(4097, 65536, 3);
        queue_req(pmmkm_pkg::KIND_MAP, 200000, 0);
        wait_idle();

        // Random phases over several meshes; heavy adds overflow slots.
        for (int ph = 0; ph < 6; ph++) begin
            ny  = (ph == 5) ? 2 : $urandom_range(2, 9);
            unq = (ph == 4) ? 1 : $urandom_range(4, 40);
            set_mesh(ny, unq, $urandom_range(0, 3));
            clear_entries(unq);
            random_phase(110, unq);
            wait_idle();  // sender holds off until all results are in
        end

        wait_idle();
        if (err_count == 0) $display("tb_top: done, clean");
        else $display("tb_top: done, errors");
        $finish;
    end

endmodule
